FILE: design/fdt_stp_pkg.sv
// ----------------------------------------------------------------------------
// fdt_stp_pkg
// Shared types and constants for the device tree structure token parser:
// token codes, parser phases, event kinds and the queued event record.
// ----------------------------------------------------------------------------
package fdt_stp_pkg;

    // token words of the structure block
    localparam logic [31:0] TOK_BEGIN   = 32'd1;
    localparam logic [31:0] TOK_ENDNODE = 32'd2;
    localparam logic [31:0] TOK_PROP    = 32'd3;
    localparam logic [31:0] TOK_NOP     = 32'd4;
    localparam logic [31:0] TOK_END     = 32'd9;

    // event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // width of the remaining value word count
    localparam int LEFT_W = 30;

    typedef enum logic [2:0] {
        KIND_BEGIN  = 3'd0,
        KIND_NAME   = 3'd1,
        KIND_ENDND  = 3'd2,
        KIND_HEADER = 3'd3,
        KIND_VALUE  = 3'd4,
        KIND_NOP    = 3'd5,
        KIND_END    = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_TOKEN = 3'd0,
        PH_NAME  = 3'd1,
        PH_LEN   = 3'd2,
        PH_OFF   = 3'd3,
        PH_VALUE = 3'd4
    } t_phase;

    // classified event, name offset still raw
    typedef struct packed {
        t_kind       kind;
        logic [31:0] data;
        logic [31:0] offset;
        logic        last;
    } t_evt;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

FILE: design/fdt_stp_ifs.sv
// ----------------------------------------------------------------------------
// fdt_stp interfaces
// Valid/ready channels for structure words, parser events and the
// strings base register write.
// ----------------------------------------------------------------------------

// structure block word channel
interface fdt_stp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        end_of_block;

    modport source (output valid, output word, output end_of_block, input ready);
    modport sink (input valid, input word, input end_of_block, output ready);
endinterface

// parser event channel
interface fdt_stp_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] data;
    logic [31:0] name_addr;
    logic        last_of_run;

    modport source (output valid, output kind, output data, output name_addr,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input data, input name_addr,
                  input last_of_run, output ready);
endinterface

// strings base write channel
interface fdt_stp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/fdt_stp_front.sv
// ----------------------------------------------------------------------------
// fdt_stp_front
// Accepts structure words, tracks the parse phase and turns each meaningful
// word into one event for the queue.
// ----------------------------------------------------------------------------
module fdt_stp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fdt_stp_word_if.sink         i_word_if,
    input  fdt_stp_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output fdt_stp_pkg::t_evt    o_evt
);

    fdt_stp_pkg::t_phase             r_phase, n_phase;
    logic [fdt_stp_pkg::LEFT_W-1:0]  r_words_left, n_words_left;
    logic [31:0]                     r_held_length, n_held_length;

    logic        accept;
    logic        zero_byte;
    logic        gen;
    logic [31:0] len_m1;

    // take a word whenever the queue has room
    assign i_word_if.ready = !i_q_stat.full;
    assign accept          = i_word_if.valid && !i_q_stat.full;
    assign o_push          = accept && gen;

    assign zero_byte = (i_word_if.word[31:24] == 8'd0) || (i_word_if.word[23:16] == 8'd0)
                    || (i_word_if.word[15:8] == 8'd0) || (i_word_if.word[7:0] == 8'd0);
    assign len_m1    = r_held_length - 32'd1;

    // classify the word and compute the next phase
    always_comb begin
        n_phase       = r_phase;
        n_words_left  = r_words_left;
        n_held_length = r_held_length;
        gen           = 1'b0;
        o_evt.kind    = fdt_stp_pkg::KIND_BEGIN;
        o_evt.data    = 32'd0;
        o_evt.offset  = 32'd0;
        o_evt.last    = 1'b0;
        case (r_phase)
            fdt_stp_pkg::PH_TOKEN: begin
                if (i_word_if.word == fdt_stp_pkg::TOK_BEGIN) begin
                    gen        = 1'b1;
                    o_evt.kind = fdt_stp_pkg::KIND_BEGIN;
                    n_phase    = fdt_stp_pkg::PH_NAME;
                end else if (i_word_if.word == fdt_stp_pkg::TOK_ENDNODE) begin
                    gen        = 1'b1;
                    o_evt.kind = fdt_stp_pkg::KIND_ENDND;
                end else if (i_word_if.word == fdt_stp_pkg::TOK_PROP) begin
                    n_phase = fdt_stp_pkg::PH_LEN;
                end else if (i_word_if.word == fdt_stp_pkg::TOK_NOP) begin
                    gen        = 1'b1;
                    o_evt.kind = fdt_stp_pkg::KIND_NOP;
                end else if (i_word_if.word == fdt_stp_pkg::TOK_END) begin
                    gen        = 1'b1;
                    o_evt.kind = fdt_stp_pkg::KIND_END;
                end
            end
            fdt_stp_pkg::PH_NAME: begin
                gen        = 1'b1;
                o_evt.kind = fdt_stp_pkg::KIND_NAME;
                o_evt.data = i_word_if.word;
                o_evt.last = zero_byte;
                if (zero_byte) begin
                    n_phase = fdt_stp_pkg::PH_TOKEN;
                end
            end
            fdt_stp_pkg::PH_LEN: begin
                n_held_length = i_word_if.word;
                n_phase       = fdt_stp_pkg::PH_OFF;
            end
            fdt_stp_pkg::PH_OFF: begin
                gen          = 1'b1;
                o_evt.kind   = fdt_stp_pkg::KIND_HEADER;
                o_evt.data   = r_held_length;
                o_evt.offset = i_word_if.word;
                o_evt.last   = (r_held_length == 32'd0);
                if (r_held_length == 32'd0) begin
                    n_phase = fdt_stp_pkg::PH_TOKEN;
                end else begin
                    // ceil(len/4) words, count the ones after the first
                    n_words_left = len_m1[31:2];
                    n_phase      = fdt_stp_pkg::PH_VALUE;
                end
            end
            fdt_stp_pkg::PH_VALUE: begin
                gen        = 1'b1;
                o_evt.kind = fdt_stp_pkg::KIND_VALUE;
                o_evt.data = i_word_if.word;
                o_evt.last = (r_words_left == '0);
                if (r_words_left == '0) begin
                    n_phase = fdt_stp_pkg::PH_TOKEN;
                end else begin
                    n_words_left = r_words_left - 1'b1;
                end
            end
            default: begin
                n_phase = fdt_stp_pkg::PH_TOKEN;
            end
        endcase
        // end of block resynchronizes to the token phase
        if (i_word_if.end_of_block) begin
            n_phase      = fdt_stp_pkg::PH_TOKEN;
            n_words_left = '0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fdt_stp_pkg::PH_TOKEN;
            r_words_left  <= '0;
            r_held_length <= 32'd0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_words_left  <= n_words_left;
            r_held_length <= n_held_length;
        end
    end

    // a pending value count only exists inside a property value
    a_left_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_words_left != '0) |-> (r_phase == fdt_stp_pkg::PH_VALUE))
        else $error("value word count pending outside value phase");

endmodule

FILE: design/fdt_stp_queue.sv
// ----------------------------------------------------------------------------
// fdt_stp_queue
// Short event queue that decouples word intake from result delivery.
// ----------------------------------------------------------------------------
module fdt_stp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fdt_stp_pkg::t_evt    i_evt,
    input  logic                 i_pop,
    output fdt_stp_pkg::t_evt    o_evt,
    output fdt_stp_pkg::t_q_stat o_stat
);

    fdt_stp_pkg::t_evt                r_mem [fdt_stp_pkg::QUEUE_DEPTH];
    logic [fdt_stp_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [fdt_stp_pkg::QUEUE_AW:0]   r_count;

    assign o_stat.full      = (r_count == (fdt_stp_pkg::QUEUE_AW + 1)'(fdt_stp_pkg::QUEUE_DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_evt            = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (fdt_stp_pkg::QUEUE_AW + 1)'(fdt_stp_pkg::QUEUE_DEPTH))
        else $error("queue fill level out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.not_empty)
        else $error("pop from empty queue");

endmodule

FILE: design/fdt_stp_back.sv
// ----------------------------------------------------------------------------
// fdt_stp_back
// Holds the strings base, forms the property name address and drives the
// registered event output.
// ----------------------------------------------------------------------------
module fdt_stp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fdt_stp_cfg_if.sink          i_cfg_if,
    input  fdt_stp_pkg::t_evt    i_evt,
    input  fdt_stp_pkg::t_q_stat i_q_stat,
    output logic                 o_pop,
    fdt_stp_evt_if.source        o_evt_if
);

    logic [31:0] r_strings_base;
    logic        r_valid;
    logic [2:0]  r_kind;
    logic [31:0] r_data;
    logic [31:0] r_name_addr;
    logic        r_last;

    // strings base register, always writable
    assign i_cfg_if.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strings_base <= 32'd0;
        end else if (i_cfg_if.valid) begin
            r_strings_base <= i_cfg_if.data;
        end
    end

    // refill the output register when it is empty or being taken
    assign o_pop = i_q_stat.not_empty && (!r_valid || o_evt_if.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_evt_if.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output payload, name address only on a header
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_evt.kind;
            r_data <= i_evt.data;
            r_last <= i_evt.last;
            if (i_evt.kind == fdt_stp_pkg::KIND_HEADER) begin
                r_name_addr <= r_strings_base + i_evt.offset;
            end else begin
                r_name_addr <= 32'd0;
            end
        end
    end

    assign o_evt_if.valid       = r_valid;
    assign o_evt_if.kind        = r_kind;
    assign o_evt_if.data        = r_data;
    assign o_evt_if.name_addr   = r_name_addr;
    assign o_evt_if.last_of_run = r_last;

    a_addr_header_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind != fdt_stp_pkg::KIND_HEADER)) |-> (r_name_addr == 32'd0))
        else $error("name address on non-header event");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_evt_if.ready) |=> (r_valid && $stable(r_data) && $stable(r_kind)))
        else $error("output register changed while stalled");

endmodule

FILE: design/fdt_structure_token_parser.sv
// ----------------------------------------------------------------------------
// fdt_structure_token_parser
// FDT structure block parser, one 32-bit word per cycle while not stalled.
// ----------------------------------------------------------------------------
// Takes one structure block word per clock, first memory byte in bits 31:24,
// and gives one event per meaningful word: begin node, name words, end node,
// property header with its length and strings base plus name offset, value
// words, nop and end. Sustained rate is one word per cycle while the queue
// has room; the front parse state updates once per word and the output side
// is a four-entry event queue then an output register, so a result passes
// through both before it is presented; a stalled sink stops intake only once
// the queue fills. Property tokens, property length words and unknown tokens
// produce no event. The user writes the strings base register over its own
// channel only while the parser is idle; the block does not enforce this.
module fdt_structure_token_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdt_stp_word_if.sink  i_word_if,
    fdt_stp_evt_if.source o_evt_if,
    fdt_stp_cfg_if.sink   i_cfg_if
);

    logic                 push;
    logic                 pop;
    fdt_stp_pkg::t_evt    front_evt;
    fdt_stp_pkg::t_evt    queue_evt;
    fdt_stp_pkg::t_q_stat q_stat;

    // word intake and classification
    fdt_stp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word_if (i_word_if),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_evt     (front_evt)
    );

    // event queue
    fdt_stp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .i_pop   (pop),
        .o_evt   (queue_evt),
        .o_stat  (q_stat)
    );

    // address forming and output register
    fdt_stp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_if (i_cfg_if),
        .i_evt    (queue_evt),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_evt_if (o_evt_if)
    );

endmodule
